FILE: sv/gra_pkg.sv
// Shared types and constants for the glitch-rejecting sample averager.
`timescale 1ns / 1ps
package gra_pkg;

  // Width of one converter sample and of the delta limit register.
  localparam int unsigned SAMPLE_W = 16;
  // Width of the accepted count field on the result beat.
  localparam int unsigned COUNT_OUT_W = 4;
  // Delta limit after reset.
  localparam logic [SAMPLE_W-1:0] DELTA_LIMIT_RESET = 16'd1000;

  // Operation codes of the shared adder/subtractor.
  typedef logic [0:0] alu_op_t;
  localparam alu_op_t ALU_ADD = 1'b0;
  localparam alu_op_t ALU_SUB = 1'b1;

  // Control group from the sequencer to the shared unit.
  typedef struct packed {
    logic    en;
    alu_op_t op;
  } alu_ctl_t;

endpackage

FILE: sv/gra_alu.sv
// Shared adder/subtractor used for differences, limit compares, accumulation and division.
`timescale 1ns / 1ps
module gra_alu #(
  parameter int unsigned W = 20
) (
  input  gra_pkg::alu_ctl_t ctl,
  input  logic [W-1:0]      a,
  input  logic [W-1:0]      b,
  output logic [W-1:0]      res,
  output logic              borrow
);
  import gra_pkg::*;

  logic [W:0] full;

  // One carry chain: a + b, or a + ~b + 1 for subtraction.
  always_comb begin
    if (!ctl.en) begin
      full = '0;
    end else if (ctl.op == ALU_SUB) begin
      full = {1'b0, a} + {1'b0, ~b} + {{W{1'b0}}, 1'b1};
    end else begin
      full = {1'b0, a} + {1'b0, b};
    end
  end

  assign res    = full[W-1:0];
  // A subtraction without carry out means a < b.
  assign borrow = (ctl.op == ALU_SUB) && ctl.en && !full[W];

endmodule

FILE: sv/glitch_rejecting_sample_averager.sv
// Top level: sequencer and datapath of the glitch-rejecting sample averager.
//
//   Channel  Direction  tdata (lowest bit up)                       tuser
//   in_      slave      high_byte[7:0], low_byte[15:8]              read_ok
//   out_     master     average[15:0], accepted_count[19:16], pad   -
//   cfg_     slave      delta_limit[15:0]                           -
//
// A failed read goes from idle straight to the advance state; a good read runs difference,
// optional reverse difference, limit compare and optional accumulate, all through one shared
// add/subtract unit. The final attempt of a window adds a restoring divide on the same unit,
// skipped when no sample was accepted, and then a load of the result register.
// in_tready is high only while the sequencer is idle. A result waits in its output register;
// the next window's result stalls in the load cycle until that beat is taken.
// rst_n is synchronous; it clears the window state and sets delta_limit to 1000.
`timescale 1ns / 1ps
module glitch_rejecting_sample_averager #(
  parameter int unsigned WINDOW = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input beat: tdata = high_byte[7:0], low_byte[15:8]; tuser = read_ok.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic [0:0]  in_tuser,
  // Result beat: tdata = average[15:0], accepted_count[19:16], zero pad[23:20].
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  // Configuration: delta_limit[15:0].
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import gra_pkg::*;

  localparam int unsigned SUM_W  = SAMPLE_W + $clog2(WINDOW);
  localparam int unsigned ALU_W  = SUM_W + 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned AT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned DIV_CW = $clog2(SUM_W);
  localparam logic [AT_W-1:0]   LAST_ATTEMPT = AT_W'(WINDOW - 1);
  localparam logic [DIV_CW-1:0] LAST_DIV     = DIV_CW'(SUM_W - 1);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIFF  = 3'd1;
  localparam logic [2:0] ST_DIFFN = 3'd2;
  localparam logic [2:0] ST_CMP   = 3'd3;
  localparam logic [2:0] ST_ACC   = 3'd4;
  localparam logic [2:0] ST_ADV   = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  logic [2:0]          state_r, state_nxt;
  logic [SAMPLE_W-1:0] limit_r, limit_nxt;
  logic [SAMPLE_W-1:0] cur_r, cur_nxt;
  logic [SAMPLE_W-1:0] prev_r, prev_nxt;
  logic [SAMPLE_W-1:0] diff_r, diff_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [AT_W-1:0]     attempt_r, attempt_nxt;
  logic [DIV_CW-1:0]   div_cnt_r, div_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_avg_r, out_avg_nxt;
  logic [COUNT_OUT_W-1:0] out_cnt_r, out_cnt_nxt;

  alu_ctl_t            alu_ctl;
  logic [ALU_W-1:0]    alu_a, alu_b, alu_res;
  logic                alu_borrow;
  logic [CNT_W:0]      shifted;
  logic [SAMPLE_W-1:0] in_sample;
  logic [31:0]         cnt_ext;

  assign in_sample = {in_tdata[7:0], in_tdata[15:8]};
  assign shifted   = {rem_r, sum_r[SUM_W-1]};
  assign cnt_ext   = 32'(cnt_r);

  gra_alu #(.W(ALU_W)) u_alu (
    .ctl    (alu_ctl),
    .a      (alu_a),
    .b      (alu_b),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  // Operand selection for the shared unit.
  always_comb begin
    alu_ctl = '{en: 1'b0, op: ALU_SUB};
    alu_a   = '0;
    alu_b   = '0;
    case (state_r)
      ST_DIFF: begin
        alu_ctl = '{en: 1'b1, op: ALU_SUB};
        alu_a   = ALU_W'(cur_r);
        alu_b   = ALU_W'(prev_r);
      end
      ST_DIFFN: begin
        alu_ctl = '{en: 1'b1, op: ALU_SUB};
        alu_a   = ALU_W'(prev_r);
        alu_b   = ALU_W'(cur_r);
      end
      ST_CMP: begin
        alu_ctl = '{en: 1'b1, op: ALU_SUB};
        alu_a   = ALU_W'(limit_r);
        alu_b   = ALU_W'(diff_r);
      end
      ST_ACC: begin
        alu_ctl = '{en: 1'b1, op: ALU_ADD};
        alu_a   = ALU_W'(sum_r);
        alu_b   = ALU_W'(cur_r);
      end
      ST_DIV: begin
        alu_ctl = '{en: 1'b1, op: ALU_SUB};
        alu_a   = ALU_W'(shifted);
        alu_b   = ALU_W'(cnt_r);
      end
      default: begin
        alu_ctl = '{en: 1'b0, op: ALU_SUB};
      end
    endcase
  end

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_nxt     = state_r;
    limit_nxt     = limit_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    diff_nxt      = diff_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    attempt_nxt   = attempt_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r;
    out_avg_nxt   = out_avg_r;
    out_cnt_nxt   = out_cnt_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_valid) begin
      limit_nxt = cfg_data;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cur_nxt = in_sample;
          if (!in_tuser[0]) begin
            state_nxt = ST_ADV;
          end else begin
            // A zero last value stands for none: start from this sample.
            if (prev_r == '0) begin
              prev_nxt = in_sample;
            end
            state_nxt = ST_DIFF;
          end
        end
      end
      ST_DIFF: begin
        diff_nxt  = alu_res[SAMPLE_W-1:0];
        state_nxt = alu_borrow ? ST_DIFFN : ST_CMP;
      end
      ST_DIFFN: begin
        diff_nxt  = alu_res[SAMPLE_W-1:0];
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        // A dropped sample still becomes the last value.
        prev_nxt  = cur_r;
        state_nxt = alu_borrow ? ST_ADV : ST_ACC;
      end
      ST_ACC: begin
        sum_nxt   = alu_res[SUM_W-1:0];
        cnt_nxt   = cnt_r + CNT_W'(1);
        state_nxt = ST_ADV;
      end
      ST_ADV: begin
        if (attempt_r == LAST_ATTEMPT) begin
          rem_nxt     = '0;
          div_cnt_nxt = '0;
          state_nxt   = (cnt_r == '0) ? ST_OUT : ST_DIV;
        end else begin
          attempt_nxt = attempt_r + AT_W'(1);
          state_nxt   = ST_IDLE;
        end
      end
      ST_DIV: begin
        // One restoring step; quotient bits shift into the sum register.
        if (alu_borrow) begin
          rem_nxt = shifted[CNT_W-1:0];
          sum_nxt = {sum_r[SUM_W-2:0], 1'b0};
        end else begin
          rem_nxt = alu_res[CNT_W-1:0];
          sum_nxt = {sum_r[SUM_W-2:0], 1'b1};
        end
        div_cnt_nxt = div_cnt_r + DIV_CW'(1);
        if (div_cnt_r == LAST_DIV) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = sum_r[SAMPLE_W-1:0];
          out_cnt_nxt   = cnt_ext[COUNT_OUT_W-1:0];
          sum_nxt       = '0;
          cnt_nxt       = '0;
          prev_nxt      = '0;
          attempt_nxt   = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and window state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      limit_r     <= DELTA_LIMIT_RESET;
      prev_r      <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      attempt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      limit_r     <= limit_nxt;
      prev_r      <= prev_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      attempt_r   <= attempt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    diff_r    <= diff_nxt;
    rem_r     <= rem_nxt;
    div_cnt_r <= div_cnt_nxt;
    out_avg_r <= out_avg_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_cnt_r, out_avg_r};

endmodule

FILE: sv/gra_checker.sv
// Port-level checks for the glitch-rejecting sample averager, bound to the top level.
`timescale 1ns / 1ps
module gra_checker #(
  parameter int unsigned WINDOW = 8
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Every input beat starts a multi-cycle job, so the block is busy right after.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  // The accepted count never exceeds the window length.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (WINDOW > 15) || (32'(out_tdata[19:16]) <= WINDOW))
    else $error("accepted count beyond window");

  // An empty window reports an average of zero.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[19:16] == 4'd0) |-> (WINDOW > 15) || (out_tdata[15:0] == 16'd0))
    else $error("non-zero average with no accepted samples");

endmodule

bind glitch_rejecting_sample_averager gra_checker #(.WINDOW(WINDOW)) u_gra_checker (.*);
